// ===== src/avhc_pkg.sv =====
// Shared types and constants for the air valve height controller.
package avhc_pkg;

  localparam int unsigned TpsW    = 20;
  localparam int unsigned TickW   = 24;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StepW   = 4;
  localparam int unsigned HeightW = 16;
  localparam int unsigned ValveN  = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 24;

  localparam logic [TickW-1:0] TickMax = {TickW{1'b1}};

  // Valve level bit positions.
  localparam logic [2:0] VbSuspFill = 3'd0;
  localparam logic [2:0] VbSuspRel  = 3'd1;
  localparam logic [2:0] VbLumbFill = 3'd2;
  localparam logic [2:0] VbLumbRel  = 3'd3;
  localparam logic [2:0] VbLumbRel2 = 3'd4;

  // Message bytes.
  localparam logic [ByteW-1:0] KindC  = 8'h43;
  localparam logic [ByteW-1:0] KindV  = 8'h56;
  localparam logic [ByteW-1:0] Sub1   = 8'h31;
  localparam logic [ByteW-1:0] Sub2   = 8'h32;
  localparam logic [ByteW-1:0] Sub3   = 8'h33;
  localparam logic [ByteW-1:0] ValOne = 8'd1;

  // Acknowledge numbers.
  localparam logic [1:0] AckNone = 2'd0;
  localparam logic [1:0] AckV1   = 2'd1;
  localparam logic [1:0] AckV2   = 2'd2;
  localparam logic [1:0] AckV3   = 2'd3;

  // Register reset values.
  localparam logic [TpsW-1:0]  TpsRst     = 20'd1000;
  localparam logic [TickW-1:0] RelRst     = 24'd4000;
  localparam logic [TickW-1:0] HbRst      = 24'd9000;
  localparam logic [ByteW-1:0] BandRst    = 8'd5;
  localparam logic [ByteW-1:0] TminRst    = 8'd60;
  localparam logic [ByteW-1:0] TmaxRst    = 8'd180;
  localparam logic [StepW-1:0] LimitRst   = 4'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TICKS_PER_SECOND = 3'd0,
    CFG_RELEASE_TICKS    = 3'd1,
    CFG_HEARTBEAT_TICKS  = 3'd2,
    CFG_BAND_HALF_WIDTH  = 3'd3,
    CFG_TARGET_MIN       = 3'd4,
    CFG_TARGET_MAX       = 3'd5,
    CFG_LUMBAR_LIMIT     = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PV_LUMB_FILL = 2'd0,
    PV_LUMB_REL  = 2'd1,
    PV_LUMB_REL2 = 2'd2,
    PV_SUSP_REL  = 2'd3
  } pulse_valve_e;

  function automatic logic [2:0] valve_bit(pulse_valve_e code);
    logic [2:0] bit_idx;
    unique case (code)
      PV_LUMB_FILL: bit_idx = VbLumbFill;
      PV_LUMB_REL:  bit_idx = VbLumbRel;
      PV_LUMB_REL2: bit_idx = VbLumbRel2;
      default:      bit_idx = VbSuspRel;
    endcase
    return bit_idx;
  endfunction

endpackage

// ===== src/air_valve_height_controller_unit.sv =====
// Top level of the air valve height controller: tick processing and valve state.
//
//  Channel  | Signals                                        | Direction
//  ---------+------------------------------------------------+----------
//  in       | in_valid_i/in_ready_o, cmd_i, msg_kind_i,      | input
//           | msg_sub_i, msg_value_i, height_sample_i        |
//  out      | out_valid_o/out_ready_i, susp_fill_o, ...,     | output
//           | heartbeat_req_o, ack_req_o, ack_valve_o        |
//  cfg      | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i | input
//
// For each tick transaction the whole state update is computed from
// the current state and the incoming item and lands, with the result, on the
// accepting edge. One transaction per cycle is sustained while out_ready_i is high.
// Reset returns all state and registers to their power-on values.
// A stalled result holds in the output register; input is taken again in the
// cycle the result leaves. Configuration writes are always accepted.
module air_valve_height_controller_unit
  import avhc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // tick input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 cmd_i,
  input  logic [ByteW-1:0]     msg_kind_i,
  input  logic [ByteW-1:0]     msg_sub_i,
  input  logic [ByteW-1:0]     msg_value_i,
  input  logic [HeightW-1:0]   height_sample_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 susp_fill_o,
  output logic                 susp_release_o,
  output logic                 lumb_fill_o,
  output logic                 lumb_release_o,
  output logic                 lumb_release_two_o,
  output logic                 heartbeat_req_o,
  output logic                 ack_req_o,
  output logic [1:0]           ack_valve_o,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDatW-1:0]   cfg_data_i
);

  // Configuration registers
  logic [TpsW-1:0]  tps_q;
  logic [TickW-1:0] rel_ticks_q, hb_ticks_q;
  logic [ByteW-1:0] band_q, tmin_q, tmax_q;
  logic [StepW-1:0] limit_q;

  // Controller state
  logic [ByteW-1:0]  target_q, target_d;
  logic [StepW-1:0]  step_q, step_d;
  logic              active_q, active_d;
  pulse_valve_e      pvalve_q, pvalve_d;
  logic [TickW-1:0]  elapsed_q, elapsed_d;
  logic [TickW-1:0]  plen_q, plen_d;
  logic [TickW-1:0]  hb_cnt_q, hb_cnt_d;
  logic              hb_started_q, hb_started_d;
  logic [ValveN-1:0] valves_q, valves_d;

  // Result register (valve levels come straight from valves_q)
  logic       out_valid_q;
  logic       hb_q, hb_d;
  logic       ack_q, ack_d;
  logic [1:0] ackv_q, ackv_d;

  logic accept;

  // Take a new tick whenever the result slot is free or draining this cycle.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Configuration write decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q       <= TpsRst;
      rel_ticks_q <= RelRst;
      hb_ticks_q  <= HbRst;
      band_q      <= BandRst;
      tmin_q      <= TminRst;
      tmax_q      <= TmaxRst;
      limit_q     <= LimitRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_TICKS_PER_SECOND: tps_q       <= cfg_data_i[TpsW-1:0];
        CFG_RELEASE_TICKS:    rel_ticks_q <= cfg_data_i;
        CFG_HEARTBEAT_TICKS:  hb_ticks_q  <= cfg_data_i;
        CFG_BAND_HALF_WIDTH:  band_q      <= cfg_data_i[ByteW-1:0];
        CFG_TARGET_MIN:       tmin_q      <= cfg_data_i[ByteW-1:0];
        CFG_TARGET_MAX:       tmax_q      <= cfg_data_i[ByteW-1:0];
        CFG_LUMBAR_LIMIT:     limit_q     <= cfg_data_i[StepW-1:0];
        default: ;  // index beyond the register list: drop the write
      endcase
    end
  end

  // One tick of work, in order: timer advance, heartbeat, message, height band,
  // pulse expiry.
  always_comb begin
    logic [ByteW-1:0]  t_clamp;
    logic [StepW-1:0]  new_step;
    logic [StepW-1:0]  diff;
    logic              up;
    logic [ByteW-1:0]  lo;
    logic [ByteW:0]    hi;
    logic              below, above;
    logic [2:0]        vb;

    target_d     = target_q;
    step_d       = step_q;
    active_d     = active_q;
    pvalve_d     = pvalve_q;
    elapsed_d    = elapsed_q;
    plen_d       = plen_q;
    hb_cnt_d     = hb_cnt_q;
    hb_started_d = hb_started_q;
    valves_d     = valves_q;
    hb_d         = 1'b0;
    ack_d        = 1'b0;
    ackv_d       = AckNone;

    // Advance the running pulse, saturating.
    if (active_q && (elapsed_q != TickMax)) begin
      elapsed_d = elapsed_q + 1'b1;
    end

    // Heartbeat: first tick always requests, then once per interval.
    if (!hb_started_q) begin
      hb_started_d = 1'b1;
      hb_cnt_d     = '0;
      hb_d         = 1'b1;
    end else begin
      if (hb_cnt_q != TickMax) begin
        hb_cnt_d = hb_cnt_q + 1'b1;
      end
      if (hb_cnt_d >= hb_ticks_q) begin
        hb_d     = 1'b1;
        hb_cnt_d = '0;
      end
    end

    // Message decode
    t_clamp  = (msg_value_i > tmax_q) ? tmax_q : msg_value_i;
    if (t_clamp < tmin_q) begin
      t_clamp = tmin_q;
    end
    new_step = (msg_value_i > {{(ByteW-StepW){1'b0}}, limit_q}) ? limit_q
                                                              : msg_value_i[StepW-1:0];
    up       = new_step > step_q;
    diff     = up ? (new_step - step_q) : (step_q - new_step);

    if (cmd_i) begin
      if ((msg_kind_i == KindC) && (msg_sub_i == Sub1)) begin
        target_d = t_clamp;
      end else if ((msg_kind_i == KindC) && (msg_sub_i == Sub2)) begin
        if (new_step != step_q) begin
          // 4 x 20 bit product always fits in 24 bits.
          active_d  = 1'b1;
          pvalve_d  = up ? PV_LUMB_FILL : PV_LUMB_REL;
          elapsed_d = '0;
          plen_d    = {{(TickW-StepW){1'b0}}, diff} * {{(TickW-TpsW){1'b0}}, tps_q};
          valves_d[valve_bit(pvalve_d)] = 1'b1;
          step_d    = new_step;
        end
      end else if ((msg_kind_i == KindV) && (msg_value_i == ValOne)) begin
        ack_d = 1'b1;
        if ((msg_sub_i == Sub1) || (msg_sub_i == Sub2) || (msg_sub_i == Sub3)) begin
          active_d  = 1'b1;
          elapsed_d = '0;
          plen_d    = rel_ticks_q;
          if (msg_sub_i == Sub1) begin
            pvalve_d = PV_SUSP_REL;
            ackv_d   = AckV1;
          end else if (msg_sub_i == Sub2) begin
            pvalve_d = PV_LUMB_REL;
            ackv_d   = AckV2;
          end else begin
            pvalve_d = PV_LUMB_REL2;
            ackv_d   = AckV3;
          end
          valves_d[valve_bit(pvalve_d)] = 1'b1;
        end
      end
    end

    // Height band; a negative lower bound means nothing is below it.
    lo    = target_d - band_q;
    hi    = {1'b0, target_d} + {1'b0, band_q};
    below = (target_d >= band_q) && (height_sample_i < {{(HeightW-ByteW){1'b0}}, lo});
    above = height_sample_i > {{(HeightW-ByteW-1){1'b0}}, hi};
    if (target_d >= tmin_q) begin
      if (below) begin
        valves_d[VbSuspFill] = 1'b1;
        valves_d[VbSuspRel]  = 1'b0;
      end else if (above) begin
        valves_d[VbSuspFill] = 1'b0;
        valves_d[VbSuspRel]  = 1'b1;
      end else if (!(active_d && (pvalve_d == PV_SUSP_REL))) begin
        valves_d[VbSuspFill] = 1'b0;
        valves_d[VbSuspRel]  = 1'b0;
      end
    end

    // Pulse expiry: drop the pulse valve once the length is reached.
    vb = valve_bit(pvalve_d);
    if (active_d && (elapsed_d >= plen_d)) begin
      valves_d[vb] = 1'b0;
      active_d     = 1'b0;
    end
  end

  // State and result registers advance together on each accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= '0;
      step_q       <= '0;
      active_q     <= 1'b0;
      pvalve_q     <= PV_LUMB_FILL;
      elapsed_q    <= '0;
      plen_q       <= '0;
      hb_cnt_q     <= '0;
      hb_started_q <= 1'b0;
      valves_q     <= '0;
      hb_q         <= 1'b0;
      ack_q        <= 1'b0;
      ackv_q       <= AckNone;
    end else if (accept) begin
      target_q     <= target_d;
      step_q       <= step_d;
      active_q     <= active_d;
      pvalve_q     <= pvalve_d;
      elapsed_q    <= elapsed_d;
      plen_q       <= plen_d;
      hb_cnt_q     <= hb_cnt_d;
      hb_started_q <= hb_started_d;
      valves_q     <= valves_d;
      hb_q         <= hb_d;
      ack_q        <= ack_d;
      ackv_q       <= ackv_d;
    end
  end

  // Result valid: set on accept, clear when taken without a replacement.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign susp_fill_o        = valves_q[VbSuspFill];
  assign susp_release_o     = valves_q[VbSuspRel];
  assign lumb_fill_o        = valves_q[VbLumbFill];
  assign lumb_release_o     = valves_q[VbLumbRel];
  assign lumb_release_two_o = valves_q[VbLumbRel2];
  assign heartbeat_req_o    = hb_q;
  assign ack_req_o          = ack_q;
  assign ack_valve_o        = ackv_q;

endmodule

// ===== verif/avhc_valve_checker.sv =====
// Checker for the air valve height controller: predicts each tick result and compares it.
module avhc_valve_checker
  import avhc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               cmd_i,
  input  logic [ByteW-1:0]   msg_kind_i,
  input  logic [ByteW-1:0]   msg_sub_i,
  input  logic [ByteW-1:0]   msg_value_i,
  input  logic [HeightW-1:0] height_sample_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               susp_fill_i,
  input  logic               susp_release_i,
  input  logic               lumb_fill_i,
  input  logic               lumb_release_i,
  input  logic               lumb_release_two_i,
  input  logic               heartbeat_req_i,
  input  logic               ack_req_i,
  input  logic [1:0]         ack_valve_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  output int unsigned        pending_o,
  output int unsigned        fail_count_o,
  output int unsigned        checked_o,
  output int unsigned        heartbeats_o,
  output int unsigned        acks_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxPrinted = 40;

  typedef struct packed {
    logic       susp_fill;
    logic       susp_rel;
    logic       lumb_fill;
    logic       lumb_rel;
    logic       lumb_rel2;
    logic       heartbeat;
    logic       ack;
    logic [1:0] ack_valve;
  } valve_result_t;

  // Shadow registers.
  logic [TpsW-1:0]   tps_q;
  logic [TickW-1:0]  rel_len_q;
  logic [TickW-1:0]  hb_period_q;
  logic [ByteW-1:0]  band_q;
  logic [ByteW-1:0]  tmin_q;
  logic [ByteW-1:0]  tmax_q;
  logic [StepW-1:0]  lumb_lim_q;

  // Shadow controller state.
  logic [ByteW-1:0]  target_q;
  logic [StepW-1:0]  lumb_step_q;
  logic              pulse_on_q;
  logic [2:0]        pulse_bit_q;
  logic [TickW-1:0]  pulse_age_q;
  logic [TickW-1:0]  pulse_len_q;
  logic [TickW-1:0]  hb_count_q;
  logic              hb_started_q;
  logic [ValveN-1:0] valves_q;

  valve_result_t expected_valves[$];
  valve_result_t got_res;
  valve_result_t want_res;

  task automatic flag_error(string msg);
    fail_count_o++;
    if (fail_count_o <= MaxPrinted) $display("%0t: result %0d: %s", $realtime, checked_o, msg);
  endtask

  task automatic check_field(string name, logic [1:0] got, logic [1:0] want);
    if (got !== want) flag_error($sformatf("%s is %b, expected %b", name, got, want));
  endtask

  task automatic start_pulse(logic [2:0] vbit, logic [TickW-1:0] len);
    pulse_on_q  = 1'b1;
    pulse_bit_q = vbit;
    pulse_age_q = '0;
    pulse_len_q = len;
    valves_q[vbit] = 1'b1;
  endtask

  // One timebase tick: pulse age, heartbeat, message, height band, then pulse expiry.
  task automatic compute_tick_result(input logic has_msg, input logic [ByteW-1:0] kind,
                                     input logic [ByteW-1:0] sub, input logic [ByteW-1:0] val,
                                     input logic [HeightW-1:0] height,
                                     output valve_result_t res);
    logic [ByteW-1:0]  tgt;
    logic [StepW-1:0]  step;
    longint unsigned   diff;
    longint unsigned   span;
    logic              up;
    int                lo;
    int                hi;
    res = '0;
    if (pulse_on_q && pulse_age_q != TickMax) pulse_age_q++;

    if (!hb_started_q) begin
      hb_started_q  = 1'b1;
      hb_count_q    = '0;
      res.heartbeat = 1'b1;
    end else begin
      if (hb_count_q != TickMax) hb_count_q++;
      if (hb_count_q >= hb_period_q) begin
        res.heartbeat = 1'b1;
        hb_count_q    = '0;
      end
    end

    if (has_msg) begin
      if (kind == KindC && sub == Sub1) begin
        tgt = (val > tmax_q) ? tmax_q : val;
        if (tgt < tmin_q) tgt = tmin_q;
        target_q = tgt;
      end else if (kind == KindC && sub == Sub2) begin
        step = (val > lumb_lim_q) ? lumb_lim_q : val[StepW-1:0];
        if (step != lumb_step_q) begin
          up   = step > lumb_step_q;
          diff = up ? step - lumb_step_q : lumb_step_q - step;
          span = diff * tps_q;
          if (span > TickMax) span = TickMax;
          start_pulse(up ? VbLumbFill : VbLumbRel, span[TickW-1:0]);
          lumb_step_q = step;
        end
      end else if (kind == KindV && val == ValOne) begin
        res.ack = 1'b1;
        case (sub)
          Sub1: begin
            start_pulse(VbSuspRel, rel_len_q);
            res.ack_valve = AckV1;
          end
          Sub2: begin
            start_pulse(VbLumbRel, rel_len_q);
            res.ack_valve = AckV2;
          end
          Sub3: begin
            start_pulse(VbLumbRel2, rel_len_q);
            res.ack_valve = AckV3;
          end
          default: res.ack_valve = AckNone;
        endcase
      end
    end

    // Bounds are signed, so the lower edge may sit below zero.
    if (target_q >= tmin_q) begin
      lo = int'(target_q) - int'(band_q);
      hi = int'(target_q) + int'(band_q);
      if (int'(height) < lo) begin
        valves_q[VbSuspFill] = 1'b1;
        valves_q[VbSuspRel]  = 1'b0;
      end else if (int'(height) > hi) begin
        valves_q[VbSuspFill] = 1'b0;
        valves_q[VbSuspRel]  = 1'b1;
      end else if (!(pulse_on_q && pulse_bit_q == VbSuspRel)) begin
        valves_q[VbSuspFill] = 1'b0;
        valves_q[VbSuspRel]  = 1'b0;
      end
    end

    if (pulse_on_q && pulse_age_q >= pulse_len_q) begin
      valves_q[pulse_bit_q] = 1'b0;
      pulse_on_q = 1'b0;
    end

    res.susp_fill = valves_q[VbSuspFill];
    res.susp_rel  = valves_q[VbSuspRel];
    res.lumb_fill = valves_q[VbLumbFill];
    res.lumb_rel  = valves_q[VbLumbRel];
    res.lumb_rel2 = valves_q[VbLumbRel2];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q        = TpsRst;
      rel_len_q    = RelRst;
      hb_period_q  = HbRst;
      band_q       = BandRst;
      tmin_q       = TminRst;
      tmax_q       = TmaxRst;
      lumb_lim_q   = LimitRst;
      target_q     = '0;
      lumb_step_q  = '0;
      pulse_on_q   = 1'b0;
      pulse_bit_q  = VbLumbFill;
      pulse_age_q  = '0;
      pulse_len_q  = '0;
      hb_count_q   = '0;
      hb_started_q = 1'b0;
      valves_q     = '0;
      expected_valves.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TICKS_PER_SECOND: tps_q       = cfg_data_i[TpsW-1:0];
          CFG_RELEASE_TICKS:    rel_len_q   = cfg_data_i[TickW-1:0];
          CFG_HEARTBEAT_TICKS:  hb_period_q = cfg_data_i[TickW-1:0];
          CFG_BAND_HALF_WIDTH:  band_q      = cfg_data_i[ByteW-1:0];
          CFG_TARGET_MIN:       tmin_q      = cfg_data_i[ByteW-1:0];
          CFG_TARGET_MAX:       tmax_q      = cfg_data_i[ByteW-1:0];
          CFG_LUMBAR_LIMIT:     lumb_lim_q  = cfg_data_i[StepW-1:0];
          default: ;
        endcase
      end

      // Compare the outgoing result before queuing this edge's prediction.
      if (out_valid_i && out_ready_i) begin
        got_res = {susp_fill_i, susp_release_i, lumb_fill_i, lumb_release_i,
                   lumb_release_two_i, heartbeat_req_i, ack_req_i, ack_valve_i};
        if (expected_valves.size() == 0) begin
          flag_error("result with no tick waiting for it");
        end else begin
          want_res = expected_valves.pop_front();
          check_field("susp_fill", got_res.susp_fill, want_res.susp_fill);
          check_field("susp_release", got_res.susp_rel, want_res.susp_rel);
          check_field("lumb_fill", got_res.lumb_fill, want_res.lumb_fill);
          check_field("lumb_release", got_res.lumb_rel, want_res.lumb_rel);
          check_field("lumb_release_two", got_res.lumb_rel2, want_res.lumb_rel2);
          check_field("heartbeat_req", got_res.heartbeat, want_res.heartbeat);
          check_field("ack_req", got_res.ack, want_res.ack);
          check_field("ack_valve", got_res.ack_valve, want_res.ack_valve);
          if (want_res.heartbeat) heartbeats_o++;
          if (want_res.ack) acks_o++;
        end
        checked_o++;
      end

      if (in_valid_i && in_ready_i) begin
        compute_tick_result(cmd_i, msg_kind_i, msg_sub_i, msg_value_i, height_sample_i,
                            want_res);
        expected_valves.push_back(want_res);
      end

      pending_o <= expected_valves.size();
    end
  end

endmodule

// ===== verif/air_valve_height_controller_unit_tb.sv =====
// Testbench top for the air valve height controller: stimulus, idling and verdict.
module air_valve_height_controller_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import avhc_pkg::*;

  localparam int unsigned HalfPeriod  = 10;
  localparam int unsigned ResetCycles = 6;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned Chunks      = 7;
  localparam int unsigned ChunkItems  = 200;

  // One tick transaction as presented on the input channel.
  typedef struct packed {
    logic               cmd;
    logic [ByteW-1:0]   kind;
    logic [ByteW-1:0]   sub;
    logic [ByteW-1:0]   value;
    logic [HeightW-1:0] height;
  } tick_t;

  logic               clk_i              = 1'b0;
  logic               rst_ni             = 1'b0;
  logic               in_valid_i         = 1'b0;
  logic               in_ready_o;
  logic               cmd_i              = 1'b0;
  logic [ByteW-1:0]   msg_kind_i         = '0;
  logic [ByteW-1:0]   msg_sub_i          = '0;
  logic [ByteW-1:0]   msg_value_i        = '0;
  logic [HeightW-1:0] height_sample_i    = '0;
  logic               out_valid_o;
  logic               out_ready_i        = 1'b0;
  logic               susp_fill_o;
  logic               susp_release_o;
  logic               lumb_fill_o;
  logic               lumb_release_o;
  logic               lumb_release_two_o;
  logic               heartbeat_req_o;
  logic               ack_req_o;
  logic [1:0]         ack_valve_o;
  logic               cfg_valid_i        = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i        = '0;
  logic [CfgDatW-1:0] cfg_data_i         = '0;

  int unsigned pending_results;
  int unsigned fail_count;
  int unsigned results_checked;
  int unsigned heartbeats_seen;
  int unsigned acks_seen;

  int unsigned cycles;
  int unsigned ticks_sent;
  int unsigned settings_used;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int          aim_height = 100;

  air_valve_height_controller_unit u_dut (.*);

  avhc_valve_checker u_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .cmd_i              (cmd_i),
    .msg_kind_i         (msg_kind_i),
    .msg_sub_i          (msg_sub_i),
    .msg_value_i        (msg_value_i),
    .height_sample_i    (height_sample_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .susp_fill_i        (susp_fill_o),
    .susp_release_i     (susp_release_o),
    .lumb_fill_i        (lumb_fill_o),
    .lumb_release_i     (lumb_release_o),
    .lumb_release_two_i (lumb_release_two_o),
    .heartbeat_req_i    (heartbeat_req_o),
    .ack_req_i          (ack_req_o),
    .ack_valve_i        (ack_valve_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .pending_o          (pending_results),
    .fail_count_o       (fail_count),
    .checked_o          (results_checked),
    .heartbeats_o       (heartbeats_seen),
    .acks_o             (acks_seen)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Abort a hung run well past the slowest legal completion.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending_results);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stall the result channel at the current rate, one decision per cycle.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one tick transaction. Idle cycles come first so valid is only
  // dropped when a gap is taken; back-to-back transactions keep it high.
  task automatic send_tick(tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= t.cmd;
    msg_kind_i      <= t.kind;
    msg_sub_i       <= t.sub;
    msg_value_i     <= t.value;
    height_sample_i <= t.height;
    do @(posedge clk_i); while (!in_ready_o);
    ticks_sent++;
  endtask

  // Hold the input channel until every predicted result has been drained.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
  endtask

  // Write all seven registers back to back, keeping valid high across them.
  task automatic program_setting(logic [CfgDatW-1:0] tps, logic [CfgDatW-1:0] rel,
                                 logic [CfgDatW-1:0] hb, logic [CfgDatW-1:0] band,
                                 logic [CfgDatW-1:0] tmin, logic [CfgDatW-1:0] tmax,
                                 logic [CfgDatW-1:0] limit);
    logic [CfgDatW-1:0] vals[7];
    cfg_reg_e           idx;
    vals = '{tps, rel, hb, band, tmin, tmax, limit};
    idx  = idx.first();
    repeat (idx.num()) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= vals[idx];
      do @(posedge clk_i); while (!cfg_ready_o);
      idx = idx.next();
    end
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Mostly well-formed commands with random content, plus plain ticks and noise.
  function automatic tick_t next_random_tick();
    tick_t       t;
    int unsigned pick;
    int          h;
    t.cmd   = 1'b1;
    t.kind  = $urandom;
    t.sub   = $urandom;
    t.value = $urandom;
    pick    = $urandom_range(99);
    if (pick < 30) begin
      t.cmd = 1'b0;
    end else if (pick < 45) begin
      t.kind  = KindC;
      t.sub   = Sub1;
      t.value = ($urandom_range(1) == 0) ? $urandom_range(255) : $urandom_range(40, 200);
      aim_height = int'(t.value);
    end else if (pick < 65) begin
      t.kind  = KindC;
      t.sub   = Sub2;
      t.value = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(15);
    end else if (pick < 82) begin
      t.kind  = KindV;
      t.value = ValOne;
      t.sub   = ($urandom_range(7) == 0) ? $urandom_range(255) : Sub1 + $urandom_range(2);
    end else if (pick < 90) begin
      t.kind  = KindV;
      t.sub   = $urandom_range(Sub1, Sub3);
    end else if (pick < 95) begin
      t.kind  = ($urandom_range(1) == 0) ? KindC : KindV;
    end

    pick = $urandom_range(99);
    if (pick < 55) begin
      h = int'($urandom_range(255));
    end else if (pick < 85) begin
      h = aim_height + int'($urandom_range(90)) - 45;
      if (h < 0) h = 0;
    end else begin
      h = int'($urandom_range(65535));
    end
    t.height = h[HeightW-1:0];
    return t;
  endfunction

  initial begin
    tick_t directed[$];
    send_idle_pct  = 36;
    recv_stall_pct = 76;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed ticks at the reset register values: first-tick heartbeat,
    // target clamps, band edges, lumbar steps, each release and ignored messages.
    directed.push_back('{1'b0, 8'h00, 8'h00, 8'h00, 16'd0});       // heartbeat, loop idle
    directed.push_back('{1'b1, KindC, Sub1, 8'd0, 16'd0});         // raise to target_min
    directed.push_back('{1'b1, KindC, Sub1, 8'd255, 16'hFFFF});    // limit to target_max
    directed.push_back('{1'b1, KindC, Sub1, 8'd100, 16'd100});     // inside band
    directed.push_back('{1'b0, 8'h00, 8'h00, 8'h00, 16'd94});      // just below band
    directed.push_back('{1'b0, 8'h00, 8'h00, 8'h00, 16'd106});     // just above band
    directed.push_back('{1'b0, 8'h00, 8'h00, 8'h00, 16'd95});      // lower edge
    directed.push_back('{1'b0, 8'h00, 8'h00, 8'h00, 16'd105});     // upper edge
    directed.push_back('{1'b1, KindC, Sub2, 8'd3, 16'd100});       // lumbar up
    directed.push_back('{1'b1, KindC, Sub2, 8'd200, 16'd100});     // clamp to limit
    directed.push_back('{1'b1, KindC, Sub2, 8'd1, 16'd100});       // lumbar down
    directed.push_back('{1'b1, KindC, Sub2, 8'd1, 16'd100});       // same step, no pulse
    directed.push_back('{1'b1, KindV, Sub1, ValOne, 16'd120});     // suspension release
    directed.push_back('{1'b0, 8'h00, 8'h00, 8'h00, 16'd100});     // band spares the pulse
    directed.push_back('{1'b1, KindV, Sub2, ValOne, 16'd100});
    directed.push_back('{1'b1, KindV, Sub3, ValOne, 16'd100});
    directed.push_back('{1'b1, KindV, 8'h37, ValOne, 16'd100});    // unknown sub, ack only
    directed.push_back('{1'b1, KindV, Sub1, 8'd0, 16'd100});       // enable not set
    directed.push_back('{1'b1, KindV, Sub1, 8'd2, 16'd100});
    directed.push_back('{1'b1, 8'h58, Sub1, 8'd5, 16'd100});       // unknown kind
    directed.push_back('{1'b1, KindC, 8'h39, 8'd5, 16'd100});      // unknown C sub
    directed.push_back('{1'b0, KindC, Sub1, 8'd200, 16'd50});      // bytes without message
    directed.push_back('{1'b1, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF});
    directed.push_back('{1'b1, KindC, Sub2, 8'd0, 16'd0});         // lumbar back to zero
    foreach (directed[i]) send_tick(directed[i]);

    for (int unsigned k = 0; k < Chunks; k++) begin
      if (k == 3) begin
        send_idle_pct  = 76;
        recv_stall_pct = 36;
      end
      if (k == 5) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      // Registers change only with the pipe empty.
      drain_results();
      case (k)
        0: program_setting(24'd1, 24'd1, 24'd0, 24'd0, 24'd0, 24'd255, 24'd15);
        1: program_setting(24'd3, 24'd5, 24'd7, 24'd4, 24'd60, 24'd180, 24'd5);
        2: program_setting(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd255, 24'd255, 24'd0,
                           24'd0);
        3: program_setting(24'd2, 24'd0, 24'd1, 24'd10, 24'd100, 24'd100, 24'd15);
        default: begin
          automatic int unsigned tmin = $urandom_range(150);
          program_setting($urandom_range(1, 6), $urandom_range(12), $urandom_range(20),
                          $urandom_range(40), tmin, $urandom_range(tmin, 255),
                          $urandom_range(15));
        end
      endcase
      repeat (ChunkItems) begin
        send_tick(next_random_tick());
        if ($urandom_range(199) == 0) drain_results();
      end
    end

    drain_results();
    repeat (4) @(posedge clk_i);

    $display("Covered %0d tick transactions under %0d register settings plus reset values,",
             ticks_sent, settings_used);
    $display("with mixed idle and stall rates; %0d results checked, %0d heartbeats, %0d acks.",
             results_checked, heartbeats_seen, acks_seen);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== air_valve_height_controller_unit.f =====
src/avhc_pkg.sv
src/air_valve_height_controller_unit.sv
verif/avhc_valve_checker.sv
verif/air_valve_height_controller_unit_tb.sv
